[hw/rtl/bdeq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared request and status codes, field widths and the per-request control
// word passed from the pointer unit to the top level of the deque.
// ----------------------------------------------------------------------------
package bdeq_pkg;

    // Default sizes
    localparam int DEF_CAPACITY   = 128;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed port field widths
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;
    localparam int WORD_W   = 32;

    // Request codes; anything else acts as a peek
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Per-request control from the pointer unit
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wr_en;
        logic                fwd_first;  // front slot is the one being written
        logic                fwd_last;   // back slot is the one being written
    } t_op_info;

endpackage : bdeq_pkg
`default_nettype wire

[hw/rtl/bounded_double_ended_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed words kept in a circular buffer. Each request
// pushes or pops at either end or peeks, and answers with status, count
// and the front and back words after the request.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_stall | i_req_type, i_push_value
//   out     | output    | o_out_valid / i_out_stall| o_status, o_element_count,
//           |           |                         | o_first_value, o_last_value,
//           |           |                         | o_is_empty
//
// In the accept cycle the pointer unit updates and both RAM copies are
// written and read; in the result state the registered read data lands in
// the output register once that register is free. No new word is taken
// during the result state. Reset clears pointer and count; the store needs
// no clearing pass. A new word is taken while a finished result waits on a
// stalled output; it then holds in the result stage until the output frees.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
    import bdeq_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic        [REQ_W-1:0]    i_req_type,
    input  wire logic signed [WORD_W-1:0]   i_push_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic             [STATUS_W-1:0] o_status,
    output logic             [COUNT_W-1:0]  o_element_count,
    output logic signed      [WORD_W-1:0]   o_first_value,
    output logic signed      [WORD_W-1:0]   o_last_value,
    output logic                            o_is_empty
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_RESULT = 1'b1;

    logic r_state, n_state;

    logic                          w_in_accept;
    logic                          w_load;
    t_op_info                      w_info;
    logic        [PTR_W-1:0]       w_wr_addr;
    logic        [PTR_W-1:0]       w_rd_first_addr;
    logic        [PTR_W-1:0]       w_rd_last_addr;
    logic        [CNT_W-1:0]       w_count;
    logic signed [DATA_WIDTH-1:0]  w_store_val;
    logic        [DATA_WIDTH-1:0]  w_first_data;
    logic        [DATA_WIDTH-1:0]  w_last_data;
    logic signed [DATA_WIDTH-1:0]  w_first_word;
    logic signed [DATA_WIDTH-1:0]  w_last_word;

    // Request held for the result cycle
    t_op_info                      r_info;
    logic        [CNT_W-1:0]       r_count;
    logic signed [DATA_WIDTH-1:0]  r_val;

    logic r_out_valid;

    assign o_in_stall  = (r_state == S_RESULT);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_load      = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);

    // Input word to stored width
    assign w_store_val = DATA_WIDTH'(i_push_value);

    // Pointer and count control
    bdeq_ptr #(
        .CAPACITY (CAPACITY)
    ) u_ptr (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_in_accept),
        .i_req_type      (i_req_type),
        .o_info          (w_info),
        .o_wr_addr       (w_wr_addr),
        .o_rd_first_addr (w_rd_first_addr),
        .o_rd_last_addr  (w_rd_last_addr),
        .o_count         (w_count)
    );

    // Two copies of the store: one read for the front, one for the back
    bdeq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram_first (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_accept && w_info.wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_store_val),
        .i_rd_en   (w_in_accept),
        .i_rd_addr (w_rd_first_addr),
        .o_rd_data (w_first_data)
    );

    bdeq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram_last (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_accept && w_info.wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_store_val),
        .i_rd_en   (w_in_accept),
        .i_rd_addr (w_rd_last_addr),
        .o_rd_data (w_last_data)
    );

    // Hold request results until the read data returns
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_info  <= w_info;
            r_count <= w_count;
            r_val   <= w_store_val;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Forwarded pushed word wins over stale read data
    assign w_first_word = r_info.fwd_first ? r_val : $signed(w_first_data);
    assign w_last_word  = r_info.fwd_last  ? r_val : $signed(w_last_data);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_status        <= r_info.status;
            o_element_count <= COUNT_W'(r_count);
            o_is_empty      <= (r_count == '0);
            if (r_count == '0) begin
                o_first_value <= '1;
                o_last_value  <= '1;
            end else begin
                o_first_value <= WORD_W'(w_first_word);
                o_last_value  <= WORD_W'(w_last_word);
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == S_RESULT))
        else $error("accepted word did not enter the result stage");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_info.status == ST_FULL)) |=>
            (o_element_count == COUNT_W'(CAPACITY)))
        else $error("full status reported with count below capacity");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_info.status == ST_EMPTY)) |=> o_is_empty)
        else $error("empty status reported on a non-empty queue");

endmodule : bounded_double_ended_queue
`default_nettype wire

[hw/rtl/bdeq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdeq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule : bdeq_ram
`default_nettype wire

[hw/rtl/bdeq_ptr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdeq_ptr
// Front pointer and fill count of the circular buffer. Decodes a request,
// checks full/empty, and produces the write slot and the front and back
// slots to read after the request.
// ----------------------------------------------------------------------------
module bdeq_ptr
    import bdeq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic [REQ_W-1:0]                  i_req_type,
    output t_op_info                               o_info,
    output logic      [$clog2(CAPACITY)-1:0]       o_wr_addr,
    output logic      [$clog2(CAPACITY)-1:0]       o_rd_first_addr,
    output logic      [$clog2(CAPACITY)-1:0]       o_rd_last_addr,
    output logic      [$clog2(CAPACITY+1)-1:0]     o_count
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = PTR_W + 1;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
    localparam logic [SUM_W-1:0] CAP_SUM   = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);

    logic [PTR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;

    logic                w_full;
    logic                w_empty;
    logic [PTR_W-1:0]    w_front_dec;
    logic [PTR_W-1:0]    w_front_inc;
    logic [SUM_W-1:0]    w_tail_sum;
    logic [PTR_W-1:0]    w_tail;
    logic [PTR_W-1:0]    w_last_off;
    logic [SUM_W-1:0]    w_last_sum;
    logic [PTR_W-1:0]    w_last;
    logic [STATUS_W-1:0] w_status;
    logic                w_wr_en;
    logic                w_fwd_first;
    logic                w_fwd_last;
    logic [PTR_W-1:0]    w_wr_addr;

    assign w_full  = (r_count == CAP_CNT);
    assign w_empty = (r_count == '0);

    // Neighbor slots of the front, with wrap
    assign w_front_dec = (r_front == '0) ? LAST_SLOT : r_front - PTR_W'(1);
    assign w_front_inc = (r_front == LAST_SLOT) ? '0 : r_front + PTR_W'(1);

    // Slot just past the back (only used when not full)
    assign w_tail_sum = {1'b0, r_front} + {1'b0, PTR_W'(r_count)};
    assign w_tail     = (w_tail_sum >= CAP_SUM) ? PTR_W'(w_tail_sum - CAP_SUM)
                                                : PTR_W'(w_tail_sum);

    // Request decode
    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        w_status  = ST_OK;
        w_wr_en   = 1'b0;
        w_wr_addr = w_tail;
        case (i_req_type)
            REQ_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_wr_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_front_dec;
                    n_front   = w_front_dec;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_front = w_front_inc;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                // peek and unused codes: no change
            end
        endcase
    end

    // Back slot after the request
    assign w_last_off = (n_count == '0) ? '0 : PTR_W'(n_count - CNT_W'(1));
    assign w_last_sum = {1'b0, n_front} + {1'b0, w_last_off};
    assign w_last     = (w_last_sum >= CAP_SUM) ? PTR_W'(w_last_sum - CAP_SUM)
                                                : PTR_W'(w_last_sum);

    // Forward the pushed word where a read hits the slot being written
    assign w_fwd_first = w_wr_en && (n_front == w_wr_addr);
    assign w_fwd_last  = w_wr_en && (w_last == w_wr_addr);

    assign o_info          = '{status:    w_status,
                               wr_en:     w_wr_en,
                               fwd_first: w_fwd_first,
                               fwd_last:  w_fwd_last};
    assign o_wr_addr       = w_wr_addr;
    assign o_rd_first_addr = n_front;
    assign o_rd_last_addr  = w_last;
    assign o_count         = n_count;

    // Pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

endmodule : bdeq_ptr
`default_nettype wire

[tb/tb_bounded_double_ended_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue
// Self-checking bench for the bounded deque. A scoreboard object keeps its
// own circular-buffer image of the queue. It predicts status, count, front
// and back words for every accepted request and compares them in order with
// the words the block returns. A short directed run covers the empty and
// single-element corners, the extreme words and the unused request codes.
// After it comes a random walk that leans toward pushes until the queue is
// full, then toward pops until it is empty, under four mixes of sender gaps
// and receiver stalls.
// ----------------------------------------------------------------------------

// One answer word of the deque, as seen on the output channel
typedef struct packed {
    logic [bdeq_pkg::STATUS_W-1:0] status;
    logic [bdeq_pkg::COUNT_W-1:0]  element_count;
    logic [bdeq_pkg::WORD_W-1:0]   first_value;
    logic [bdeq_pkg::WORD_W-1:0]   last_value;
    logic                          is_empty;
} t_deque_view;

class t_deque_scoreboard;
    localparam int SLOT_W = $clog2(bdeq_pkg::DEF_CAPACITY);

    // Shadow copy of the store, head slot and fill level
    logic [bdeq_pkg::WORD_W-1:0]  slot_words [bdeq_pkg::DEF_CAPACITY];
    logic [SLOT_W-1:0]            head_slot;
    logic [bdeq_pkg::COUNT_W-1:0] fill_level;
    t_deque_view                  expected_views [$];
    int unsigned                  fail_count;

    function new();
        head_slot  = '0;
        fill_level = '0;
        fail_count = 0;
    endfunction

    function int pending();
        return expected_views.size();
    endfunction

    // Apply one accepted request and queue the answer it must produce
    function void note_request(logic [bdeq_pkg::REQ_W-1:0] req,
                               logic [bdeq_pkg::WORD_W-1:0] word);
        t_deque_view       view;
        logic [SLOT_W-1:0] tail_slot;
        view.status = bdeq_pkg::ST_OK;
        case (req)
            bdeq_pkg::REQ_PUSH_BACK, bdeq_pkg::REQ_PUSH_FRONT: begin
                if (fill_level == bdeq_pkg::DEF_CAPACITY) begin
                    view.status = bdeq_pkg::ST_FULL;
                end else if (req == bdeq_pkg::REQ_PUSH_BACK) begin
                    tail_slot = SLOT_W'((int'(head_slot) + int'(fill_level))
                                        % bdeq_pkg::DEF_CAPACITY);
                    slot_words[tail_slot] = word;
                    fill_level++;
                end else begin
                    head_slot = (head_slot == '0)
                                ? SLOT_W'(bdeq_pkg::DEF_CAPACITY - 1)
                                : head_slot - SLOT_W'(1);
                    slot_words[head_slot] = word;
                    fill_level++;
                end
            end
            bdeq_pkg::REQ_POP_BACK, bdeq_pkg::REQ_POP_FRONT: begin
                if (fill_level == 0) begin
                    view.status = bdeq_pkg::ST_EMPTY;
                end else begin
                    if (req == bdeq_pkg::REQ_POP_FRONT)
                        head_slot = SLOT_W'((int'(head_slot) + 1)
                                            % bdeq_pkg::DEF_CAPACITY);
                    fill_level--;
                end
            end
            default: ;  // peek and unused codes leave the queue alone
        endcase
        // Empty queue reads all ones at both ends
        if (fill_level == 0) begin
            view.first_value = '1;
            view.last_value  = '1;
        end else begin
            tail_slot = SLOT_W'((int'(head_slot) + int'(fill_level) - 1)
                                % bdeq_pkg::DEF_CAPACITY);
            view.first_value = slot_words[head_slot];
            view.last_value  = slot_words[tail_slot];
        end
        view.element_count = fill_level;
        view.is_empty      = (fill_level == 0);
        expected_views.push_back(view);
    endfunction

    // Compare one returned word with the oldest prediction
    function void check_result(t_deque_view got);
        t_deque_view want;
        if (expected_views.size() == 0) begin
            $error("unexpected answer word: status %0d count %0d",
                   got.status, got.element_count);
            fail_count++;
            return;
        end
        want = expected_views.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, got.element_count);
            fail_count++;
        end
        if (got.first_value !== want.first_value) begin
            $error("first_value: expected %h, got %h",
                   want.first_value, got.first_value);
            fail_count++;
        end
        if (got.last_value !== want.last_value) begin
            $error("last_value: expected %h, got %h",
                   want.last_value, got.last_value);
            fail_count++;
        end
        if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            fail_count++;
        end
    endfunction
endclass

module tb_bounded_double_ended_queue;
    import bdeq_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int ITEMS_PER_MIX = 160;
    localparam int CYCLE_LIMIT   = 300000;

    // Unused request codes, all handled as a peek
    localparam logic [REQ_W-1:0] REQ_SPARE_0 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_1 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_2 = 3'd7;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic                       o_in_stall;
    logic        [REQ_W-1:0]    i_req_type    = REQ_PEEK;
    logic signed [WORD_W-1:0]   i_push_value  = '0;
    logic                       o_out_valid;
    logic                       i_out_stall   = 1'b0;
    logic        [STATUS_W-1:0] o_status;
    logic        [COUNT_W-1:0]  o_element_count;
    logic signed [WORD_W-1:0]   o_first_value;
    logic signed [WORD_W-1:0]   o_last_value;
    logic                       o_is_empty;

    t_deque_scoreboard sb = new();
    int unsigned       cycle_count  = 0;
    int unsigned       tx_idle_pct  = 0;
    int unsigned       rx_stall_pct = 0;
    bit                filling      = 1'b1;

    bounded_double_ended_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_push_value    (i_push_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_first_value   (o_first_value),
        .o_last_value    (o_last_value),
        .o_is_empty      (o_is_empty)
    );

    always #6 i_clk = ~i_clk;

    // Receiver back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0)
                sb.note_request(i_req_type, i_push_value);
            if (o_out_valid === 1'b1 && !i_out_stall)
                sb.check_result('{o_status, o_element_count, o_first_value,
                                  o_last_value, o_is_empty});
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bounded_double_ended_queue regression: fail");
            $finish;
        end
    end

    // Random sender gap, starting at the next falling edge
    task automatic sender_gap();
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Present one request word and hold it until taken
    task automatic drive_request(logic [REQ_W-1:0] req, logic [WORD_W-1:0] word);
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_push_value <= word;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic send(logic [REQ_W-1:0] req, logic [WORD_W-1:0] word);
        sender_gap();
        drive_request(req, word);
    endtask

    // Hold the sender off until every answer is back
    task automatic drain_answers();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random walk: lean toward pushes until full, then toward pops until empty
    task automatic send_walk_step();
        logic [REQ_W-1:0]  req;
        logic [WORD_W-1:0] word;
        int unsigned       roll;
        sender_gap();
        if (filling && sb.fill_level == CAPACITY && $urandom_range(2) == 0)
            filling = 1'b0;
        else if (!filling && sb.fill_level == 0 && $urandom_range(2) == 0)
            filling = 1'b1;
        roll = $urandom_range(99);
        if (roll < 70)
            req = filling ? ($urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK)
                          : ($urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK);
        else if (roll < 85)
            req = filling ? ($urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK)
                          : ($urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK);
        else if (roll < 95)
            req = REQ_PEEK;
        else
            req = REQ_W'($urandom_range(REQ_SPARE_2, REQ_SPARE_0));
        case ($urandom_range(15))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7fff_ffff;
            2:       word = '1;
            default: word = $urandom();
        endcase
        drive_request(req, word);
    endtask

    initial begin
        // Synchronous reset
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty corners, unused codes, extreme words
        send(REQ_PEEK,       '0);
        send(REQ_POP_BACK,   '1);
        send(REQ_POP_FRONT,  '0);
        send(REQ_SPARE_0,    '0);
        send(REQ_SPARE_1,    '1);
        send(REQ_SPARE_2,    '0);
        send(REQ_PUSH_BACK,  32'h7fff_ffff);
        send(REQ_PUSH_FRONT, 32'h8000_0000);
        send(REQ_PEEK,       '1);
        send(REQ_PUSH_BACK,  32'hffff_ffff);
        send(REQ_PUSH_FRONT, 32'h0000_0000);
        send(REQ_SPARE_0,    32'h1234_5678);
        send(REQ_POP_FRONT,  '0);
        send(REQ_POP_BACK,   '0);
        send(REQ_POP_FRONT,  '0);
        send(REQ_POP_BACK,   '0);
        send(REQ_POP_FRONT,  '0);
        send(REQ_PUSH_FRONT, 32'h5555_5555);
        send(REQ_POP_BACK,   '0);
        send(REQ_PUSH_BACK,  32'haaaa_aaaa);
        send(REQ_POP_FRONT,  '0);

        // Random walk under each idling mix
        for (int mix = 0; mix < 4; mix++) begin
            drain_answers();
            case (mix)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 87; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 87; end
                default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
            endcase
            for (int n = 0; n < ITEMS_PER_MIX; n++)
                send_walk_step();
        end

        // Wind down
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("bounded_double_ended_queue regression: pass");
        else
            $display("bounded_double_ended_queue regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
